// ===== sv/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

   // Widths fixed by the register and the item fields
   localparam int SIZE_W   = 11;   // block sizes and header positions
   localparam int REQ_W    = 11;   // request_bytes
   localparam int OFF_W    = 10;   // release_offset and data_offset
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam logic [SIZE_W-1:0] HEAP_RESET = 11'd1024;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic              has_next;
      logic [SIZE_W-1:0] next;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef struct packed {
      logic              fits;    // block holds the rounded request
      logic              split;   // enough left over for a new header and one alignment unit
      logic [SIZE_W-1:0] left;    // size kept by the block after a split
      logic [SIZE_W-1:0] tail;    // header position of the split-off tail
   } fit_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REL_RD,
      S_REL_WR,
      S_WALK,
      S_CHECK,
      S_SPLIT,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== sv/ffa_ram.sv =====
`default_nettype none
module ffa_ram #(
   parameter int WIDTH = 23,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/ffa_fit.sv =====
`default_nettype none
module ffa_fit #(
   parameter int HEADER_BYTES = 16,
   parameter int ALIGN_BYTES  = 8
) (
   input  wire logic [ffa_pkg::SIZE_W-1:0] size,
   input  wire logic [ffa_pkg::SIZE_W:0]   req,
   input  wire logic [ffa_pkg::SIZE_W-1:0] cur,
   output      ffa_pkg::fit_type           fit
);
   import ffa_pkg::*;

   localparam logic [SIZE_W+1:0] SPLIT_MIN = (SIZE_W+2)'(HEADER_BYTES + ALIGN_BYTES);
   localparam logic [SIZE_W-1:0] HDR       = SIZE_W'(HEADER_BYTES);

   logic [SIZE_W+1:0] need;
   logic [SIZE_W-1:0] left;

   // one compare pair and one subtract chain, reused for every header of the walk
   assign need = {1'b0, req} + SPLIT_MIN;
   assign left = size - req[SIZE_W-1:0] - HDR;

   always_comb begin
      fit.fits  = {1'b0, size} >= req;
      fit.split = {2'b00, size} >= need;
      fit.left  = left;
      fit.tail  = cur + HDR + left;
   end

endmodule
`default_nettype wire

// ===== sv/first_fit_free_list_allocator.sv =====
// First-fit free-list allocator over a fixed heap of block headers.
//
// req channel: one item per operation. tuser is kind (allocate or release);
// tdata carries request_bytes and release_offset. rsp channel: one item per
// request, tdata carries data_offset, tuser carries granted.
// csr port: csr_we with csr_wdata writes heap_bytes and reformats the heap
// into one free block; the block then rewrites the first
// header before it takes a request.
//
// Steps, from the accepting edge to rsp_tvalid: a release reads the header,
// writes it back and hands off the result, or only hands off the result when
// it is ignored. An allocate reads and then fit-checks each header visited on
// the free list, then hands off the result when the block is unlinked whole,
// or first rewrites the shrunk block when it is split; a failed walk hands off
// once its end is seen. The walk gives up after HEAP_BYTES + 1 headers.
// req_tready rises again in the cycle that rsp_tvalid rises.
// Reset reformats the heap to the default size, same as a csr write.
// The result register decouples the channels: a new request may be accepted
// while rsp waits; a second result holds until rsp_tready takes the first.
// ALIGN_BYTES must be a power of two.
`default_nettype none
module first_fit_free_list_allocator #(
   parameter int HEAP_BYTES   = 1024,
   parameter int HEADER_BYTES = 16,
   parameter int ALIGN_BYTES  = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [10:0] request_bytes, [20:11] release_offset, [23:21] zero
   input  wire logic [ffa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] kind
   input  wire logic                               req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [9:0] data_offset, [15:10] zero
   output      logic [ffa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] granted
   output      logic                               rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [ffa_pkg::SIZE_W-1:0]         csr_wdata
);
   import ffa_pkg::*;

   // headers only ever sit below the effective heap size, which the register caps
   localparam int MEM_DEPTH = (HEAP_BYTES < 2048) ? HEAP_BYTES : 2048;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int STEP_W    = $clog2(HEAP_BYTES + 2);
   localparam logic [SIZE_W-1:0] HDR       = SIZE_W'(HEADER_BYTES);
   localparam logic [SIZE_W:0]   ALIGN_M1  = (SIZE_W+1)'(ALIGN_BYTES - 1);
   localparam logic [STEP_W-1:0] STEP_CAP  = STEP_W'(HEAP_BYTES);

   function automatic logic [SIZE_W-1:0] clip_heap(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = (32'(v) > HEAP_BYTES) ? SIZE_W'(HEAP_BYTES) : v;
      return r;
   endfunction

   // control and walk state
   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] heap_ff, heap_in;
   logic              fmt_pending_ff, fmt_pending_in;
   logic [SIZE_W-1:0] head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic [SIZE_W:0]   req_ff, req_in;
   logic [SIZE_W-1:0] cur_ff, cur_in;
   logic              cur_ok_ff, cur_ok_in;
   logic [SIZE_W-1:0] prev_ff, prev_in;
   logic              prev_ok_ff, prev_ok_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   hdr_type           hdr_ff, hdr_in;
   logic [OFF_W-1:0]  res_off_ff, res_off_in;
   logic              res_grant_ff, res_grant_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic              rsp_grant_ff, rsp_grant_in;

   // header RAM port
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   hdr_type           mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   hdr_type           mem_rdata;

   // request fields
   logic [REQ_W-1:0]  in_req_bytes;
   logic [OFF_W-1:0]  in_roff;
   logic [SIZE_W:0]   in_req_round;
   logic [SIZE_W-1:0] in_pos;
   logic              in_range;
   logic [SIZE_W-1:0] eff_heap;
   logic [SIZE_W-1:0] fmt_size;
   fit_type           fit;

   assign in_req_bytes = req_tdata[REQ_W-1:0];
   assign in_roff      = req_tdata[REQ_W+OFF_W-1:REQ_W];
   assign in_req_round = ({1'b0, in_req_bytes} + ALIGN_M1) & ~ALIGN_M1;
   assign in_pos       = {1'b0, in_roff} - HDR;
   assign eff_heap     = clip_heap(heap_ff);
   assign in_range     = ({1'b0, in_roff} >= HDR) && (in_pos < eff_heap);
   assign fmt_size     = (eff_heap >= HDR) ? (eff_heap - HDR) : '0;

   assign req_tready = (state_ff == S_IDLE) && !fmt_pending_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-OFF_W)'(0), rsp_off_ff};
   assign rsp_tuser  = rsp_grant_ff;

   ffa_ram #(
      .WIDTH($bits(hdr_type)),
      .DEPTH(MEM_DEPTH)
   ) u_hdr_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // fit check on the header just read
   ffa_fit #(
      .HEADER_BYTES(HEADER_BYTES),
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_fit (
      .size(mem_rdata.size),
      .req (req_ff),
      .cur (cur_ff),
      .fit (fit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         heap_ff        <= HEAP_RESET;
         fmt_pending_ff <= 1'b1;
         head_ff        <= '0;
         head_valid_ff  <= clip_heap(HEAP_RESET) >= HDR;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         heap_ff        <= heap_in;
         fmt_pending_ff <= fmt_pending_in;
         head_ff        <= head_in;
         head_valid_ff  <= head_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      cur_ok_ff    <= cur_ok_in;
      prev_ff      <= prev_in;
      prev_ok_ff   <= prev_ok_in;
      steps_ff     <= steps_in;
      hdr_ff       <= hdr_in;
      res_off_ff   <= res_off_in;
      res_grant_ff <= res_grant_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_grant_ff <= rsp_grant_in;
   end

   always_comb begin
      state_in       = state_ff;
      heap_in        = heap_ff;
      fmt_pending_in = fmt_pending_ff;
      head_in        = head_ff;
      head_valid_in  = head_valid_ff;
      req_in         = req_ff;
      cur_in         = cur_ff;
      cur_ok_in      = cur_ok_ff;
      prev_in        = prev_ff;
      prev_ok_in     = prev_ok_ff;
      steps_in       = steps_ff;
      hdr_in         = hdr_ff;
      res_off_in     = res_off_ff;
      res_grant_in   = res_grant_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_grant_in   = rsp_grant_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = '0;

      // drain the result register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (fmt_pending_ff) begin
               // lay down the single free block at position zero
               mem_we         = 1'b1;
               mem_waddr      = '0;
               mem_wdata      = '{has_next: 1'b0, next: '0, size: fmt_size};
               fmt_pending_in = 1'b0;
            end else if (req_tvalid) begin
               if (req_tuser == KIND_RELEASE) begin
                  res_off_in   = in_roff;
                  res_grant_in = 1'b0;
                  cur_in       = in_pos;
                  state_in     = in_range ? S_REL_RD : S_DONE;
               end else begin
                  req_in     = in_req_round;
                  cur_in     = head_ff;
                  cur_ok_in  = head_valid_ff;
                  prev_ok_in = 1'b0;
                  steps_in   = '0;
                  state_in   = S_WALK;
               end
            end
         end
         S_REL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(cur_ff);
            state_in  = S_REL_WR;
         end
         S_REL_WR: begin
            // push the block on the list head, keep its size
            mem_we        = 1'b1;
            mem_waddr     = AW'(cur_ff);
            mem_wdata     = '{has_next: head_valid_ff, next: head_ff, size: mem_rdata.size};
            head_in       = cur_ff;
            head_valid_in = 1'b1;
            res_grant_in  = 1'b1;
            state_in      = S_DONE;
         end
         S_WALK: begin
            if (!cur_ok_ff || (steps_ff > STEP_CAP)) begin
               // end of list or a cycle: fail
               res_off_in   = '0;
               res_grant_in = 1'b0;
               state_in     = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = AW'(cur_ff);
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            // hdr_ff still holds the previous header here
            steps_in = steps_ff + 1'b1;
            hdr_in   = mem_rdata;
            if (fit.fits) begin
               res_grant_in = 1'b1;
               if (fit.split) begin
                  // hand out the tail, shrink the block in place next cycle
                  mem_we        = 1'b1;
                  mem_waddr     = AW'(fit.tail);
                  mem_wdata     = '{has_next: 1'b0, next: '0, size: req_ff[SIZE_W-1:0]};
                  hdr_in.size   = fit.left;
                  res_off_in    = OFF_W'(fit.tail + HDR);
                  state_in      = S_SPLIT;
               end else begin
                  if (prev_ok_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(prev_ff);
                     mem_wdata = '{has_next: mem_rdata.has_next, next: mem_rdata.next,
                                   size: hdr_ff.size};
                  end else begin
                     head_in       = mem_rdata.next;
                     head_valid_in = mem_rdata.has_next;
                  end
                  res_off_in = OFF_W'(cur_ff + HDR);
                  state_in   = S_DONE;
               end
            end else begin
               // advance along the list
               prev_in    = cur_ff;
               prev_ok_in = 1'b1;
               cur_in     = mem_rdata.next;
               cur_ok_in  = mem_rdata.has_next;
               state_in   = S_WALK;
            end
         end
         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cur_ff);
            mem_wdata = hdr_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_grant_in = res_grant_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // heap size write: reformat
      if (csr_we) begin
         heap_in        = csr_wdata;
         fmt_pending_in = 1'b1;
         head_in        = '0;
         head_valid_in  = clip_heap(csr_wdata) >= HDR;
      end
   end

   a_cfg_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("request accepted before reformat finished");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_tready) |=>
         (state_ff == S_DONE && rsp_valid_ff))
      else $error("result lost while receiver stalled");

   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK || state_ff == S_REL_RD) |-> !mem_we)
      else $error("header write during a read step");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> $past(mem_re))
      else $error("fit check without a header read");

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (steps_ff <= STEP_CAP))
      else $error("walk ran past its limit");

endmodule
`default_nettype wire
